// ===== design/twada_pkg.sv =====
// Shared types and constants for the triggered wave average decay-time core.
// Used by twada_seq and triggered_wave_average_decay_time_core; no dependencies.
package twada_pkg;

  localparam int MAX_SAMPLES_DEF  = 16384;
  localparam int MAX_WAVE_LEN_DEF = 4096;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_WAVES_DEF    = 256;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_FRACTION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_FRACTION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMPLITUDE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRACTION  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FRACTION = 3'd6;

  localparam logic [14:0] RST_SAMPLE_COUNT    = 15'd16384;
  localparam logic [8:0]  RST_WAVE_COUNT      = 9'd16;
  localparam logic [15:0] RST_UPPER_FRACTION  = 16'd52429;
  localparam logic [15:0] RST_LOWER_FRACTION  = 16'd13107;
  localparam logic [15:0] RST_MIN_AMPLITUDE   = 16'd1000;
  localparam logic [15:0] RST_FIRST_FRACTION  = 16'd58982;
  localparam logic [15:0] RST_SECOND_FRACTION = 16'd24109;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_LOW_VOLT = 2'd1;
  localparam logic [1:0] STATUS_NO_WAVE  = 2'd2;

  typedef struct packed {
    logic [15:0] upper_fraction;
    logic [15:0] lower_fraction;
    logic [15:0] min_amplitude;
    logic [15:0] first_fraction;
    logic [15:0] second_fraction;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_THR, ST_CLR, ST_S_RD, ST_S_EV, ST_W_SET, ST_W_RD, ST_W_EV,
    ST_W_CHK, ST_A_RD, ST_A_WR, ST_W_NEXT, ST_FINAL, ST_L_RD0, ST_L_RD1, ST_L_WL,
    ST_C_RD, ST_C_EV, ST_OUT
  } state_t;

endpackage

// ===== design/twada_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module twada_ram #(
  parameter int W = 16,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/twada_mul.sv =====
// Shared registered multiplier for thresholds and crossing levels.
// No dependencies.
module twada_mul #(
  parameter int AW = 25,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/twada_seq.sv =====
// Measurement sequencer: thresholds, pulse walk, wave accumulation, crossing scan.
// Depends on twada_pkg, twada_ram, twada_mul.
module twada_seq #(
  parameter int MAX_SAMPLES  = twada_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_WAVE_LEN = twada_pkg::MAX_WAVE_LEN_DEF,
  parameter int SAMPLE_BITS  = twada_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WAVES    = twada_pkg::MAX_WAVES_DEF,
  localparam int IDX_W = $clog2(MAX_SAMPLES + 1),
  localparam int SAW   = $clog2(MAX_SAMPLES),
  localparam int LEN_W = $clog2(MAX_WAVE_LEN + 1),
  localparam int CNT_W = $clog2(MAX_WAVES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] peak_in,
  input  logic [SAMPLE_BITS-1:0] floor_in,
  input  logic [IDX_W-1:0]       count,
  input  logic [CNT_W-1:0]       waves,
  input  twada_pkg::cfg_t        cfg,
  output logic                   busy,
  output logic [SAW-1:0]         s_raddr,
  input  logic [SAMPLE_BITS-1:0] s_rdata,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic signed [LEN_W:0]  decay_samples,
  output logic [LEN_W-1:0]       wave_length,
  output logic [CNT_W-1:0]       waves_added,
  output logic [SAMPLE_BITS-1:0] peak,
  output logic [SAMPLE_BITS-1:0] floor
);

  localparam int WAW   = $clog2(MAX_WAVE_LEN);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int BW    = 17;
  localparam int ACC_W = SUM_W + BW + 1;
  localparam int XW    = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 3;

  twada_pkg::state_t state, state_next;

  logic [SAMPLE_BITS-1:0] peak_q, peak_q_next, floor_q, floor_q_next;
  logic [ACC_W-1:0]       acc0, acc0_next, acc1, acc1_next;
  logic [2:0]             k, k_next;
  logic                   lvl_mode, lvl_mode_next;
  logic [LEN_W-1:0]       ptr, ptr_next;
  logic [IDX_W-1:0]       start_q, start_q_next, n, n_next, i, i_next;
  logic                   high, high_next;
  logic [SAMPLE_BITS-1:0] maxv, maxv_next;
  logic [IDX_W-1:0]       maxpos, maxpos_next, lastpos, lastpos_next;
  logic                   max_ok, max_ok_next, last_ok, last_ok_next;
  logic [LEN_W-1:0]       len, len_next, j, j_next;
  logic [CNT_W-1:0]       times, times_next;
  logic [SUM_W-1:0]       w0, w0_next, wl, wl_next;
  logic [LEN_W-1:0]       p1, p1_next, p2, p2_next;
  logic                   f1, f1_next, f2, f2_next;
  logic [1:0]             res_status, res_status_next;
  logic signed [LEN_W:0]  res_decay, res_decay_next;
  logic [LEN_W-1:0]       res_len, res_len_next;
  logic [CNT_W-1:0]       res_times, res_times_next;

  logic                   w_we;
  logic [WAW-1:0]         w_waddr, w_raddr;
  logic [SUM_W-1:0]       w_wdata, w_rdata;
  logic [SUM_W-1:0]       mul_a;
  logic [BW-1:0]          mul_b;
  logic [SUM_W+BW-1:0]    mul_p;

  logic [ACC_W-1:0]       vs, ws_s;
  logic [XW-1:0]          d, six, base, dm, cap, len_new, tail_end, add_addr;
  logic [IDX_W-1:0]       walk_addr;
  logic [CNT_W+3:0]       times10, waves9;
  logic                   below1, below2, f1n, f2n;
  logic [LEN_W-1:0]       p1n, p2n;

  twada_ram #(.W(SUM_W), .D(MAX_WAVE_LEN)) u_wave (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  twada_mul #(.AW(SUM_W), .BW(BW)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p(mul_p)
  );

  assign busy = (state != twada_pkg::ST_IDLE);

  // operand select: thresholds (peak, floor) or levels (w[0], w[L-1])
  always_comb begin
    if (!lvl_mode) begin
      mul_a = k[0] ? SUM_W'(floor_q) : SUM_W'(peak_q);
      mul_b = (k[1:0] == 2'd0 || k[1:0] == 2'd3) ? BW'(cfg.upper_fraction)
                                                 : BW'(cfg.lower_fraction);
    end else begin
      mul_a = k[0] ? wl : w0;
      case (k[1:0])
        2'd0:    mul_b = BW'(cfg.first_fraction);
        2'd1:    mul_b = 17'h10000 - BW'(cfg.first_fraction);
        2'd2:    mul_b = BW'(cfg.second_fraction);
        default: mul_b = 17'h10000 - BW'(cfg.second_fraction);
      endcase
    end
  end

  always_comb begin
    vs        = ACC_W'({s_rdata, 16'b0});
    ws_s      = ACC_W'({w_rdata, 16'b0});
    d         = XW'(i - maxpos);
    six       = (d << 2) + (d << 1);
    if (len != '0) base = XW'(len);
    else if (six > XW'(MAX_WAVE_LEN)) base = XW'(MAX_WAVE_LEN);
    else base = six;
    dm        = XW'(maxpos - lastpos);
    cap       = ((dm << 1) + dm) >> 2;
    len_new   = (last_ok && cap < base) ? cap : base;
    tail_end  = XW'(len) + XW'(maxpos);
    walk_addr = start_q + i;
    add_addr  = XW'(start_q) + XW'(maxpos) + XW'(j);
    times10   = (CNT_W+4)'({times, 3'b0}) + (CNT_W+4)'({times, 1'b0});
    waves9    = (CNT_W+4)'({waves, 3'b0}) + (CNT_W+4)'(waves);
    below1    = ws_s < acc0;
    below2    = ws_s < acc1;
    f1n       = f1 || below1;
    f2n       = f2 || below2;
    p1n       = f1 ? p1 : j;
    p2n       = f2 ? p2 : j;
  end

  always_comb begin
    state_next      = state;
    peak_q_next     = peak_q;
    floor_q_next    = floor_q;
    acc0_next       = acc0;
    acc1_next       = acc1;
    k_next          = k;
    lvl_mode_next   = lvl_mode;
    ptr_next        = ptr;
    start_q_next    = start_q;
    n_next          = n;
    i_next          = i;
    high_next       = high;
    maxv_next       = maxv;
    maxpos_next     = maxpos;
    lastpos_next    = lastpos;
    max_ok_next     = max_ok;
    last_ok_next    = last_ok;
    len_next        = len;
    j_next          = j;
    times_next      = times;
    w0_next         = w0;
    wl_next         = wl;
    p1_next         = p1;
    p2_next         = p2;
    f1_next         = f1;
    f2_next         = f2;
    res_status_next = res_status;
    res_decay_next  = res_decay;
    res_len_next    = res_len;
    res_times_next  = res_times;
    s_raddr         = walk_addr[SAW-1:0];
    w_raddr         = j[WAW-1:0];
    w_we            = 1'b0;
    w_waddr         = j[WAW-1:0];
    w_wdata         = SUM_W'(w_rdata + SUM_W'(s_rdata));

    case (state)
      twada_pkg::ST_IDLE: begin
        if (start) begin
          peak_q_next  = peak_in;
          floor_q_next = floor_in;
          state_next   = twada_pkg::ST_CHECK;
        end
      end
      twada_pkg::ST_CHECK: begin
        if (32'(peak_q) < 32'(cfg.min_amplitude)) begin
          res_status_next = twada_pkg::STATUS_LOW_VOLT;
          res_decay_next  = '0;
          res_len_next    = '0;
          res_times_next  = '0;
          state_next      = twada_pkg::ST_OUT;
        end else begin
          acc0_next     = '0;
          acc1_next     = '0;
          k_next        = '0;
          lvl_mode_next = 1'b0;
          state_next    = twada_pkg::ST_THR;
        end
      end
      twada_pkg::ST_THR: begin
        if (k != 3'd0) begin
          if (k <= 3'd2) acc0_next = acc0 + ACC_W'(mul_p);
          else acc1_next = acc1 + ACC_W'(mul_p);
        end
        if (k == 3'd4) begin
          if (!lvl_mode) begin
            ptr_next   = '0;
            state_next = twada_pkg::ST_CLR;
          end else begin
            j_next     = '0;
            f1_next    = 1'b0;
            f2_next    = 1'b0;
            state_next = twada_pkg::ST_C_RD;
          end
        end else begin
          k_next = k + 3'd1;
        end
      end
      twada_pkg::ST_CLR: begin
        w_we    = 1'b1;
        w_waddr = ptr[WAW-1:0];
        w_wdata = '0;
        ptr_next = ptr + LEN_W'(1);
        if (ptr == LEN_W'(MAX_WAVE_LEN - 1)) begin
          start_q_next = '0;
          state_next   = twada_pkg::ST_S_RD;
        end
      end
      twada_pkg::ST_S_RD: begin
        s_raddr = start_q[SAW-1:0];
        if (start_q == count) state_next = twada_pkg::ST_W_SET;
        else state_next = twada_pkg::ST_S_EV;
      end
      twada_pkg::ST_S_EV: begin
        if (vs > acc1) begin
          start_q_next = start_q + IDX_W'(1);
          state_next   = twada_pkg::ST_S_RD;
        end else begin
          state_next = twada_pkg::ST_W_SET;
        end
      end
      twada_pkg::ST_W_SET: begin
        n_next       = count - start_q;
        i_next       = '0;
        high_next    = 1'b0;
        max_ok_next  = 1'b0;
        last_ok_next = 1'b0;
        len_next     = '0;
        times_next   = '0;
        if (count == start_q) state_next = twada_pkg::ST_FINAL;
        else state_next = twada_pkg::ST_W_RD;
      end
      twada_pkg::ST_W_RD: begin
        state_next = twada_pkg::ST_W_EV;
      end
      twada_pkg::ST_W_EV: begin
        state_next = twada_pkg::ST_W_NEXT;
        if (!high) begin
          if (vs >= acc0) begin
            high_next    = 1'b1;
            maxv_next    = s_rdata;
            lastpos_next = maxpos;
            last_ok_next = max_ok;
            maxpos_next  = i;
            max_ok_next  = 1'b1;
          end
        end else if (maxv < s_rdata) begin
          maxv_next   = s_rdata;
          maxpos_next = i;
        end else if (vs <= acc1) begin
          high_next  = 1'b0;
          len_next   = LEN_W'(len_new);
          state_next = twada_pkg::ST_W_CHK;
        end
      end
      twada_pkg::ST_W_CHK: begin
        j_next = '0;
        if (tail_end >= XW'(n)) begin
          state_next = twada_pkg::ST_FINAL;
        end else if (len == '0) begin
          times_next = times + CNT_W'(1);
          state_next = twada_pkg::ST_W_NEXT;
        end else begin
          state_next = twada_pkg::ST_A_RD;
        end
      end
      twada_pkg::ST_A_RD: begin
        s_raddr    = add_addr[SAW-1:0];
        state_next = twada_pkg::ST_A_WR;
      end
      twada_pkg::ST_A_WR: begin
        w_we = 1'b1;
        if (j + LEN_W'(1) == len) begin
          times_next = times + CNT_W'(1);
          state_next = twada_pkg::ST_W_NEXT;
        end else begin
          j_next     = j + LEN_W'(1);
          state_next = twada_pkg::ST_A_RD;
        end
      end
      twada_pkg::ST_W_NEXT: begin
        if (times >= waves || i + IDX_W'(1) >= n) begin
          state_next = twada_pkg::ST_FINAL;
        end else begin
          i_next     = i + IDX_W'(1);
          state_next = twada_pkg::ST_W_RD;
        end
      end
      twada_pkg::ST_FINAL: begin
        res_times_next = times;
        res_decay_next = '0;
        if (times10 < waves9 || times == '0) begin
          res_status_next = twada_pkg::STATUS_NO_WAVE;
          res_len_next    = '0;
          state_next      = twada_pkg::ST_OUT;
        end else begin
          res_len_next = len;
          if (len == '0) begin
            res_status_next = twada_pkg::STATUS_LOW_VOLT;
            state_next      = twada_pkg::ST_OUT;
          end else begin
            state_next = twada_pkg::ST_L_RD0;
          end
        end
      end
      twada_pkg::ST_L_RD0: begin
        w_raddr    = '0;
        state_next = twada_pkg::ST_L_RD1;
      end
      twada_pkg::ST_L_RD1: begin
        w0_next    = w_rdata;
        w_raddr    = WAW'(len - LEN_W'(1));
        state_next = twada_pkg::ST_L_WL;
      end
      twada_pkg::ST_L_WL: begin
        wl_next       = w_rdata;
        acc0_next     = '0;
        acc1_next     = '0;
        k_next        = '0;
        lvl_mode_next = 1'b1;
        state_next    = twada_pkg::ST_THR;
      end
      twada_pkg::ST_C_RD: begin
        state_next = twada_pkg::ST_C_EV;
      end
      twada_pkg::ST_C_EV: begin
        f1_next = f1n;
        f2_next = f2n;
        p1_next = p1n;
        p2_next = p2n;
        if (f1n && f2n) begin
          res_status_next = twada_pkg::STATUS_OK;
          res_decay_next  = $signed({1'b0, p2n}) - $signed({1'b0, p1n});
          state_next      = twada_pkg::ST_OUT;
        end else if (j + LEN_W'(1) == len) begin
          res_status_next = twada_pkg::STATUS_LOW_VOLT;
          res_decay_next  = '0;
          state_next      = twada_pkg::ST_OUT;
        end else begin
          j_next     = j + LEN_W'(1);
          state_next = twada_pkg::ST_C_RD;
        end
      end
      twada_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) state_next = twada_pkg::ST_IDLE;
      end
      default: state_next = twada_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twada_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    peak_q     <= peak_q_next;
    floor_q    <= floor_q_next;
    acc0       <= acc0_next;
    acc1       <= acc1_next;
    k          <= k_next;
    lvl_mode   <= lvl_mode_next;
    ptr        <= ptr_next;
    start_q    <= start_q_next;
    n          <= n_next;
    i          <= i_next;
    high       <= high_next;
    maxv       <= maxv_next;
    maxpos     <= maxpos_next;
    lastpos    <= lastpos_next;
    max_ok     <= max_ok_next;
    last_ok    <= last_ok_next;
    len        <= len_next;
    j          <= j_next;
    times      <= times_next;
    w0         <= w0_next;
    wl         <= wl_next;
    p1         <= p1_next;
    p2         <= p2_next;
    f1         <= f1_next;
    f2         <= f2_next;
    res_status <= res_status_next;
    res_decay  <= res_decay_next;
    res_len    <= res_len_next;
    res_times  <= res_times_next;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == twada_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == twada_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      status        <= res_status;
      decay_samples <= res_decay;
      wave_length   <= res_len;
      waves_added   <= res_times;
      peak          <= peak_q;
      floor         <= floor_q;
    end
  end

endmodule

// ===== design/triggered_wave_average_decay_time_core.sv =====
// Capture loader, configuration registers and measurement sequencer instance.
// Depends on twada_pkg, twada_ram, twada_seq.
//
// Samples are taken one word per cycle whenever in_stall is low, into the capture memory, while
// the peak and floor are tracked. The last sample of a capture starts a measurement, during
// which in_stall is high: range check and threshold setup on the shared multiplier, a clear
// of the wave-sum memory over all MAX_WAVE_LEN words, a start search, a pulse walk, one check
// per fall and the accumulation of each wave point, level setup on the shared multiplier and a
// crossing scan. All of these run through the single read port of each memory. One result
// word is produced per capture and is held in an output register until taken; a finished
// measurement waits, still stalling the input, while that register holds an untaken word.
module triggered_wave_average_decay_time_core #(
  parameter int MAX_SAMPLES  = twada_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_WAVE_LEN = twada_pkg::MAX_WAVE_LEN_DEF,
  parameter int SAMPLE_BITS  = twada_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WAVES    = twada_pkg::MAX_WAVES_DEF,
  localparam int LEN_W = $clog2(MAX_WAVE_LEN + 1),
  localparam int CNT_W = $clog2(MAX_WAVES + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [twada_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twada_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_BITS-1:0]               sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic signed [LEN_W:0]                decay_samples,
  output logic [LEN_W-1:0]                     wave_length,
  output logic [CNT_W-1:0]                     waves_added,
  output logic [SAMPLE_BITS-1:0]               peak,
  output logic [SAMPLE_BITS-1:0]               floor
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int SAW   = $clog2(MAX_SAMPLES);

  logic [14:0]      sample_count;
  logic [8:0]       wave_count;
  twada_pkg::cfg_t  cfg;

  logic [IDX_W-1:0]       load_index, count_eff;
  logic [CNT_W-1:0]       waves_eff;
  logic [SAMPLE_BITS-1:0] running_peak, running_floor, peak_next, floor_next;
  logic                   accept, last, busy;
  logic [SAW-1:0]         s_raddr;
  logic [SAMPLE_BITS-1:0] s_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count        <= twada_pkg::RST_SAMPLE_COUNT;
      wave_count          <= twada_pkg::RST_WAVE_COUNT;
      cfg.upper_fraction  <= twada_pkg::RST_UPPER_FRACTION;
      cfg.lower_fraction  <= twada_pkg::RST_LOWER_FRACTION;
      cfg.min_amplitude   <= twada_pkg::RST_MIN_AMPLITUDE;
      cfg.first_fraction  <= twada_pkg::RST_FIRST_FRACTION;
      cfg.second_fraction <= twada_pkg::RST_SECOND_FRACTION;
    end else if (cfg_write) begin
      case (cfg_index)
        twada_pkg::CFG_SAMPLE_COUNT:    sample_count        <= cfg_data[14:0];
        twada_pkg::CFG_WAVE_COUNT:      wave_count          <= cfg_data[8:0];
        twada_pkg::CFG_UPPER_FRACTION:  cfg.upper_fraction  <= cfg_data;
        twada_pkg::CFG_LOWER_FRACTION:  cfg.lower_fraction  <= cfg_data;
        twada_pkg::CFG_MIN_AMPLITUDE:   cfg.min_amplitude   <= cfg_data;
        twada_pkg::CFG_FIRST_FRACTION:  cfg.first_fraction  <= cfg_data;
        twada_pkg::CFG_SECOND_FRACTION: cfg.second_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample_count == '0) count_eff = IDX_W'(1);
    else if (32'(sample_count) > MAX_SAMPLES) count_eff = IDX_W'(MAX_SAMPLES);
    else count_eff = IDX_W'(sample_count);
    if (32'(wave_count) > MAX_WAVES) waves_eff = CNT_W'(MAX_WAVES);
    else waves_eff = CNT_W'(wave_count);
  end

  assign in_stall   = busy;
  assign accept     = in_valid && !in_stall;
  assign last       = (load_index + IDX_W'(1)) >= count_eff;
  assign peak_next  = (sample > running_peak) ? sample : running_peak;
  assign floor_next = (sample < running_floor) ? sample : running_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index    <= '0;
      running_peak  <= '0;
      running_floor <= '1;
    end else if (accept) begin
      if (last) begin
        load_index    <= '0;
        running_peak  <= '0;
        running_floor <= '1;
      end else begin
        load_index    <= load_index + IDX_W'(1);
        running_peak  <= peak_next;
        running_floor <= floor_next;
      end
    end
  end

  twada_ram #(.W(SAMPLE_BITS), .D(MAX_SAMPLES)) u_store (
    .clk(clk),
    .we(accept && (32'(load_index) < MAX_SAMPLES)),
    .waddr(load_index[SAW-1:0]),
    .wdata(sample),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  twada_seq #(
    .MAX_SAMPLES(MAX_SAMPLES), .MAX_WAVE_LEN(MAX_WAVE_LEN),
    .SAMPLE_BITS(SAMPLE_BITS), .MAX_WAVES(MAX_WAVES)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(accept && last),
    .peak_in(peak_next),
    .floor_in(floor_next),
    .count(count_eff),
    .waves(waves_eff),
    .cfg(cfg),
    .busy(busy),
    .s_raddr(s_raddr),
    .s_rdata(s_rdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .decay_samples(decay_samples),
    .wave_length(wave_length),
    .waves_added(waves_added),
    .peak(peak),
    .floor(floor)
  );

endmodule

// ===== dv/twada_checker.sv =====
// Watches the config port and both word channels of the decay-time core, predicts each
// measurement result and compares it field by field. Depends on twada_pkg.
`timescale 1ns / 1ps
module twada_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic signed [13:0] decay_samples,
  input  logic [12:0]        wave_length,
  input  logic [8:0]         waves_added,
  input  logic [15:0]        peak,
  input  logic [15:0]        floor,
  output int                 errors,
  output int                 pending
);

  localparam int CAP_DEPTH = 16384;
  localparam int SUM_DEPTH = 4096;
  localparam int WAVE_LIMIT = 256;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [13:0] decay;
    logic [12:0]        wlen;
    logic [8:0]         nwaves;
    logic [15:0]        pk;
    logic [15:0]        fl;
  } meas_t;

  logic [15:0] cap_mem [CAP_DEPTH];
  longint unsigned wsum [SUM_DEPTH];
  logic [14:0] scount;
  logic [8:0]  wcount;
  logic [15:0] upper_q, lower_q, min_amp, frac1, frac2;
  int unsigned load_idx;
  logic [15:0] run_pk, run_fl;
  meas_t meas_q[$];

  function automatic int unsigned capture_len();
    if (scount == 0) return 1;
    if (scount > CAP_DEPTH) return CAP_DEPTH;
    return scount;
  endfunction

  function automatic int crossing_at(longint len, longint unsigned frac);
    longint unsigned level;
    level = wsum[0] * frac + wsum[len - 1] * (65536 - frac);
    for (longint i = 0; i < len; i++)
      if ((wsum[i] << 16) < level) return int'(i);
    return -1;
  endfunction

  function automatic meas_t measure();
    meas_t r;
    longint unsigned cnt, pk, fl, waves, hq, lq, start, vs;
    longint n, maxpos, lastpos, len, times, cap;
    logic [15:0] v, maxv;
    bit high;
    int p1, p2;
    cnt = capture_len();
    pk = run_pk;
    fl = run_fl;
    waves = (wcount > WAVE_LIMIT) ? WAVE_LIMIT : wcount;
    maxpos = -1; lastpos = -1; len = 0; times = 0; maxv = 0; high = 0; start = 0;
    r = '{status: twada_pkg::STATUS_LOW_VOLT, decay: '0, wlen: '0, nwaves: '0,
          pk: run_pk, fl: run_fl};
    if (pk < min_amp) return r;
    hq = pk * upper_q + fl * lower_q;
    lq = pk * lower_q + fl * upper_q;
    while (start < cnt && (longint'(cap_mem[start]) << 16) > lq) start++;
    n = cnt - start;
    for (int k = 0; k < SUM_DEPTH; k++) wsum[k] = 0;
    for (longint i = 0; i < n; i++) begin
      v = cap_mem[start + i];
      vs = longint'(v) << 16;
      if (!high) begin
        if (vs >= hq) begin
          high = 1; maxv = v; lastpos = maxpos; maxpos = i;
        end
      end else if (maxv < v) begin
        maxv = v; maxpos = i;
      end else if (vs <= lq) begin
        high = 0;
        if (len == 0) begin
          len = (i - maxpos) * 6;
          if (len > SUM_DEPTH) len = SUM_DEPTH;
        end
        if (lastpos >= 0) begin
          cap = (maxpos - lastpos) * 3 / 4;
          if (cap < len) len = cap;
        end
        if (len + maxpos >= n) break;
        for (longint j = 0; j < len; j++) wsum[j] += cap_mem[start + maxpos + j];
        times++;
      end
      if (times >= waves) break;
    end
    r.nwaves = times[8:0];
    if (times * 10 < waves * 9 || times == 0) begin
      r.status = twada_pkg::STATUS_NO_WAVE;
      return r;
    end
    r.wlen = len[12:0];
    if (len <= 0) return r;
    p1 = crossing_at(len, frac1);
    p2 = crossing_at(len, frac2);
    if (p1 < 0 || p2 < 0) return r;
    r.status = twada_pkg::STATUS_OK;
    r.decay = 14'(p2 - p1);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 30) $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    meas_t e;
    if (rst) begin
      scount <= twada_pkg::RST_SAMPLE_COUNT;
      wcount <= twada_pkg::RST_WAVE_COUNT;
      upper_q <= twada_pkg::RST_UPPER_FRACTION;
      lower_q <= twada_pkg::RST_LOWER_FRACTION;
      min_amp <= twada_pkg::RST_MIN_AMPLITUDE;
      frac1 <= twada_pkg::RST_FIRST_FRACTION;
      frac2 <= twada_pkg::RST_SECOND_FRACTION;
      load_idx = 0;
      run_pk = 0;
      run_fl = '1;
      meas_q.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          twada_pkg::CFG_SAMPLE_COUNT:    scount <= cfg_data[14:0];
          twada_pkg::CFG_WAVE_COUNT:      wcount <= cfg_data[8:0];
          twada_pkg::CFG_UPPER_FRACTION:  upper_q <= cfg_data;
          twada_pkg::CFG_LOWER_FRACTION:  lower_q <= cfg_data;
          twada_pkg::CFG_MIN_AMPLITUDE:   min_amp <= cfg_data;
          twada_pkg::CFG_FIRST_FRACTION:  frac1 <= cfg_data;
          twada_pkg::CFG_SECOND_FRACTION: frac2 <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (load_idx < CAP_DEPTH) cap_mem[load_idx] = sample;
        if (sample > run_pk) run_pk = sample;
        if (sample < run_fl) run_fl = sample;
        load_idx++;
        if (load_idx >= capture_len()) begin
          e = measure();
          meas_q = {meas_q, e};
          pending++;
          load_idx = 0;
          run_pk = 0;
          run_fl = '1;
        end
      end
      if (out_valid && !out_stall) begin
        if (meas_q.size() == 0) begin
          report_mismatch("result word with no expectation");
        end else begin
          e = meas_q.pop_front();
          pending--;
          if (status !== e.status)
            report_mismatch($sformatf("status %0d exp %0d", status, e.status));
          if (decay_samples !== e.decay)
            report_mismatch($sformatf("decay_samples %0d exp %0d", decay_samples, e.decay));
          if (wave_length !== e.wlen)
            report_mismatch($sformatf("wave_length %0d exp %0d", wave_length, e.wlen));
          if (waves_added !== e.nwaves)
            report_mismatch($sformatf("waves_added %0d exp %0d", waves_added, e.nwaves));
          if (peak !== e.pk) report_mismatch($sformatf("peak %0d exp %0d", peak, e.pk));
          if (floor !== e.fl) report_mismatch($sformatf("floor %0d exp %0d", floor, e.fl));
        end
      end
    end
  end
endmodule

// ===== dv/tb.sv =====
// Top of the decay-time core testbench: clock, reset, config writes and sample stimulus.
// Depends on twada_pkg, the core and twada_checker.
`timescale 1ns / 1ps
module tb;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic [15:0] sample = '0;
  logic in_stall, out_valid;
  logic [1:0] status;
  logic signed [13:0] decay_samples;
  logic [12:0] wave_length;
  logic [8:0] waves_added;
  logic [15:0] peak, floor;
  int errors, pending;

  int idle_pct = 0, stall_pct = 0, hold_len = 0, items_sent = 0;
  bit hold_req = 0;
  int per = 8, amp = 40000, base = 100, sh = 1, noise = 3;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  triggered_wave_average_decay_time_core DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .status, .decay_samples, .wave_length, .waves_added,
    .peak, .floor
  );

  twada_checker chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall, .sample,
    .out_valid, .out_stall, .status, .decay_samples, .wave_length, .waves_added,
    .peak, .floor, .errors, .pending
  );

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_len = 12000;
    end
    if (hold_len > 0) begin
      hold_len--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(input logic [15:0] v);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1;
    sample <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // mode 0 pulse train, 1 full-range noise, 2 flat
  function automatic logic [15:0] wave_point(int k, int mode);
    int ph, v;
    if (mode == 1) return 16'($urandom);
    if (mode == 2) return 16'(base);
    ph = k % per;
    if (ph == 0) return 16'(base);
    v = base + ((amp - base) >>> ((ph - 1) * sh)) + $urandom_range(0, noise);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  task automatic send_capture(input int cnt, input int mode);
    for (int k = 0; k < cnt; k++) send_word(wave_point(k, mode));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_wr(input logic [2:0] idx, input int val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input int up, input int lo, input int ma, input int f1,
                                input int f2);
    cfg_wr(twada_pkg::CFG_UPPER_FRACTION, up);
    cfg_wr(twada_pkg::CFG_LOWER_FRACTION, lo);
    cfg_wr(twada_pkg::CFG_MIN_AMPLITUDE, ma);
    cfg_wr(twada_pkg::CFG_FIRST_FRACTION, f1);
    cfg_wr(twada_pkg::CFG_SECOND_FRACTION, f2);
  endtask

  task automatic pick_shape();
    per = $urandom_range(4, 16);
    base = $urandom_range(0, 3000);
    amp = $urandom_range(base + 2000, 65535);
    sh = $urandom_range(1, 2);
    noise = $urandom_range(0, 200);
  endtask

  initial begin
    int cnt, phase, mode;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    @(negedge clk);

    // single-sample captures at both sample extremes, and low voltage
    cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, 0);
    send_word(16'h0000);
    send_word(16'hFFFF);
    drain();
    cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, 1);
    send_word(16'h5A5A);
    drain();
    // pulse train that averages cleanly
    cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, 24);
    cfg_wr(twada_pkg::CFG_WAVE_COUNT, 2);
    set_thresholds(52429, 13107, 0, 58982, 24109);
    per = 8; base = 200; amp = 60000; sh = 1; noise = 0;
    send_capture(24, 0);
    drain();
    // too few waves, then flat line with no crossing, then fraction extremes
    cfg_wr(twada_pkg::CFG_WAVE_COUNT, 256);
    send_capture(24, 0);
    drain();
    cfg_wr(twada_pkg::CFG_WAVE_COUNT, 0);
    cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, 6);
    send_capture(6, 2);
    drain();
    cfg_wr(twada_pkg::CFG_WAVE_COUNT, 511);
    set_thresholds(65535, 0, 65535, 0, 65535);
    send_capture(6, 0);
    drain();
    // capture count lowered while loading
    set_thresholds(52429, 13107, 1000, 58982, 24109);
    cfg_wr(twada_pkg::CFG_WAVE_COUNT, 1);
    cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, 20);
    per = 5;
    send_capture(5, 0);
    drain();
    cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, 3);
    send_word(16'd300);
    drain();

    // long receiver hold-off while captures keep coming
    cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, 8);
    hold_req = 1;
    for (int c = 0; c < 3; c++) begin
      pick_shape();
      send_capture(8, 0);
    end
    drain();

    phase = 0;
    while (items_sent < 1000) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      phase++;
      pick_shape();
      cnt = $urandom_range(8, 64);
      drain();
      cfg_wr(twada_pkg::CFG_SAMPLE_COUNT, cnt);
      cfg_wr(twada_pkg::CFG_WAVE_COUNT, $urandom_range(0, 9) == 0 ? $urandom_range(0, 511)
                                                      : $urandom_range(1, cnt / per + 1));
      if ($urandom_range(3) == 0)
        set_thresholds($urandom, $urandom, $urandom, $urandom, $urandom);
      else
        set_thresholds($urandom_range(40000, 60000), $urandom_range(3000, 25000),
                       $urandom_range(0, 2000), $urandom_range(30000, 65535),
                       $urandom_range(0, 40000));
      for (int c = 0; c < 3; c++) begin
        mode = ($urandom_range(5) == 0) ? $urandom_range(1, 2) : 0;
        send_capture(cnt, mode);
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
